[sv/fpsr_pkg.sv]
package fpsr_pkg;

    localparam int OP_W      = 2;
    localparam int RAW_W     = 16;
    localparam int TEMP_W    = 8;
    localparam int DUTY_W    = 7;
    localparam int SPEED_W   = 8;
    localparam int ACC_W     = 8;
    localparam int TICK_W    = 10;
    localparam int PULSE_W   = 16;
    localparam int TARGET_W  = 6;
    localparam int DIV_W     = 16;
    localparam int DEN_W     = 9;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [TICK_W-1:0]  TICKS_PER_UPDATE = 10'd1000;
    localparam logic [DUTY_W-1:0]  PWM_PERIOD       = 7'd100;
    localparam logic [DUTY_W-1:0]  DUTY_OFF_VALUE   = 7'd80;
    localparam logic [TEMP_W-1:0]  THRESHOLD_RESET  = 8'd80;
    localparam logic [DEN_W-1:0]   SPEED_DIVISOR    = 9'd360;
    localparam logic [DEN_W-1:0]   TARGET_MODULUS   = 9'd40;
    localparam logic [RAW_W-1:0]   TEMP_ROUND       = 16'd8;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_PULSE  = 2'd1,
        OP_SAMPLE = 2'd2
    } t_op;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DEN_W-1:0] remainder;
    } t_div_rsp;

endpackage

[sv/fpsr_if.sv]
interface fpsr_item_if import fpsr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [RAW_W-1:0] sensor_raw;

    modport source (output valid, output operation, output sensor_raw, input ready);
    modport sink (input valid, input operation, input sensor_raw, output ready);
endinterface

interface fpsr_cfg_if import fpsr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TEMP_W-1:0] threshold_temp;

    modport source (output valid, output threshold_temp, input ready);
    modport sink (input valid, input threshold_temp, output ready);
endinterface

interface fpsr_result_if import fpsr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               fan_drive;
    logic [DUTY_W-1:0]  duty_level;
    logic [SPEED_W-1:0] fan_speed;
    logic               motor_on;
    logic [TEMP_W-1:0]  current_temp;
    logic               sample_request;

    modport source (
        output valid, output fan_drive, output duty_level, output fan_speed,
        output motor_on, output current_temp, output sample_request, input ready
    );
    modport sink (
        input valid, input fan_drive, input duty_level, input fan_speed,
        input motor_on, input current_temp, input sample_request, output ready
    );
endinterface

[sv/fpsr_div.sv]
module fpsr_div import fpsr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_num;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_den;

    logic [DEN_W:0] w_trial;
    logic [DEN_W:0] w_diff;
    logic           w_fit;

    // one quotient bit per cycle, restoring
    always_comb begin
        w_trial = {r_rem, r_num[DIV_W-1]};
        w_fit   = (w_trial >= {1'b0, r_den});
        w_diff  = w_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_W-2:0], w_fit};
            r_rem <= w_fit ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_num;
    assign o_rsp.remainder = r_rem;

endmodule

[sv/fan_pwm_speed_regulator.sv]
// channel    | dir | handshake     | payload
// i_item     | in  | valid / ready | operation, sensor_raw
// i_cfg      | in  | valid / ready | threshold_temp
// o_result   | out | valid / ready | fan_drive, duty_level, fan_speed, motor_on,
//            |     |               | current_temp, sample_request
// pulse and sample transactions go from accept through S_TICKEND and S_EMIT, a plain tick through S_MOD first
// a tick that wraps the accumulator waits in S_MOD for the serial remainder division
// the update tick adds 16-step divisions on the shared divider for speed, quotient and target
// input ready is high whenever the sequencer is idle, even while a result waits
// reset is synchronous: threshold 80, duty 80, all counts and outputs cleared
module fan_pwm_speed_regulator import fpsr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    fpsr_item_if.sink            i_item,
    fpsr_cfg_if.sink             i_cfg,
    fpsr_result_if.source        o_result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_TICKEND,
        S_SPD,
        S_QUOT,
        S_TGT,
        S_STEP,
        S_EMIT
    } t_state;

    t_state               r_state;
    logic [OP_W-1:0]      r_op;
    logic [RAW_W-1:0]     r_raw;
    logic [TEMP_W-1:0]    r_threshold;
    logic [TICK_W-1:0]    r_tick_count;
    logic [ACC_W-1:0]     r_accum;
    logic [DUTY_W-1:0]    r_duty;
    logic [PULSE_W-1:0]   r_pulse_count;
    logic [SPEED_W-1:0]   r_speed;
    logic [TEMP_W-1:0]    r_temp;
    logic                 r_fan_on;
    logic                 r_drive;
    logic                 r_request;
    logic [TARGET_W-1:0]  r_target;
    logic                 r_out_valid;
    logic                 r_out_drive;
    logic [DUTY_W-1:0]    r_out_duty;
    logic [SPEED_W-1:0]   r_out_speed;
    logic                 r_out_fan_on;
    logic [TEMP_W-1:0]    r_out_temp;
    logic                 r_out_request;
    t_div_req             r_div_req;
    t_div_rsp             w_div_rsp;

    logic                 w_accept;
    logic [PULSE_W-1:0]   w_pulse60;
    logic [DIV_W-1:0]     w_diff;
    logic [DIV_W-1:0]     w_scaled;
    logic [RAW_W-1:0]     w_rounded;
    logic [TEMP_W-1:0]    w_temp;
    logic [SPEED_W-1:0]   w_target_ext;

    fpsr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign i_item.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign w_accept     = i_item.valid && (r_state == S_IDLE);

    always_comb begin
        w_pulse60    = (r_pulse_count << 6) - (r_pulse_count << 2);
        w_diff       = {{(DIV_W-TEMP_W){1'b0}}, r_temp} - {{(DIV_W-TEMP_W){1'b0}}, r_threshold};
        w_scaled     = (w_diff << 5) + (w_diff << 3);
        w_rounded    = r_raw + TEMP_ROUND;
        w_temp       = w_rounded[TEMP_W+3:4];
        w_target_ext = {{(SPEED_W-TARGET_W){1'b0}}, r_target};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_op          <= '0;
            r_raw         <= '0;
            r_threshold   <= THRESHOLD_RESET;
            r_tick_count  <= '0;
            r_accum       <= '0;
            r_duty        <= DUTY_OFF_VALUE;
            r_pulse_count <= '0;
            r_speed       <= '0;
            r_temp        <= '0;
            r_fan_on      <= 1'b0;
            r_drive       <= 1'b0;
            r_request     <= 1'b0;
            r_target      <= '0;
            r_out_valid   <= 1'b0;
            r_out_drive   <= 1'b0;
            r_out_duty    <= '0;
            r_out_speed   <= '0;
            r_out_fan_on  <= 1'b0;
            r_out_temp    <= '0;
            r_out_request <= 1'b0;
            r_div_req     <= '0;
        end else begin
            r_div_req.start <= 1'b0;
            if (i_cfg.valid) begin
                r_threshold <= i_cfg.threshold_temp;
            end
            if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op      <= i_item.operation;
                        r_raw     <= i_item.sensor_raw;
                        r_request <= 1'b0;
                        r_state   <= S_MOD;
                        if (t_op'(i_item.operation) != OP_TICK) begin
                            r_state <= S_TICKEND;
                        end
                    end
                end
                S_MOD: begin
                    // tick pwm step; wrap case waits for the serial remainder
                    if (!r_fan_on) begin
                        r_duty  <= DUTY_OFF_VALUE;
                        r_accum <= '0;
                        r_drive <= 1'b0;
                        r_state <= S_TICKEND;
                    end else if (r_accum < {1'b0, PWM_PERIOD}) begin
                        r_drive <= 1'b0;
                        r_accum <= r_accum + {1'b0, r_duty};
                        r_state <= S_TICKEND;
                    end else if (!r_div_req.start && w_div_rsp.done) begin
                        r_drive <= 1'b1;
                        r_accum <= w_div_rsp.remainder[ACC_W-1:0] + {1'b0, r_duty};
                        r_state <= S_TICKEND;
                    end else if (r_raw[0] == 1'b0) begin
                        r_raw[0]           <= 1'b1;
                        r_div_req.start    <= 1'b1;
                        r_div_req.dividend <= {{(DIV_W-ACC_W){1'b0}}, r_accum};
                        r_div_req.divisor  <= {{(DEN_W-DUTY_W){1'b0}}, PWM_PERIOD};
                    end
                end
                S_TICKEND: begin
                    r_state <= S_EMIT;
                    unique case (t_op'(r_op))
                        OP_TICK: begin
                            if (r_tick_count == TICKS_PER_UPDATE) begin
                                r_tick_count       <= '0;
                                r_request          <= 1'b1;
                                r_div_req.start    <= 1'b1;
                                r_div_req.dividend <= w_pulse60;
                                r_div_req.divisor  <= SPEED_DIVISOR;
                                r_state            <= S_SPD;
                            end else begin
                                r_tick_count <= r_tick_count + 1'b1;
                            end
                        end
                        OP_PULSE: begin
                            r_pulse_count <= r_pulse_count + 1'b1;
                        end
                        OP_SAMPLE: begin
                            r_temp   <= w_temp;
                            r_fan_on <= (w_temp > r_threshold);
                        end
                        default: begin
                        end
                    endcase
                end
                S_SPD: begin
                    if (w_div_rsp.done) begin
                        r_speed       <= w_div_rsp.quotient[SPEED_W-1:0];
                        r_pulse_count <= '0;
                        if (r_temp == '0) begin
                            r_target <= TARGET_W'(1);
                            r_state  <= S_STEP;
                        end else begin
                            r_div_req.start    <= 1'b1;
                            r_div_req.dividend <= w_scaled;
                            r_div_req.divisor  <= {{(DEN_W-TEMP_W){1'b0}}, r_temp};
                            r_state            <= S_QUOT;
                        end
                    end
                end
                S_QUOT: begin
                    if (w_div_rsp.done) begin
                        r_div_req.start    <= 1'b1;
                        r_div_req.dividend <= w_div_rsp.quotient;
                        r_div_req.divisor  <= TARGET_MODULUS;
                        r_state            <= S_TGT;
                    end
                end
                S_TGT: begin
                    if (w_div_rsp.done) begin
                        r_target <= w_div_rsp.remainder[TARGET_W-1:0] + 1'b1;
                        r_state  <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (r_speed > w_target_ext) begin
                        if (r_duty != '0 && r_fan_on) begin
                            r_duty  <= r_duty - 1'b1;
                            r_accum <= '0;
                        end
                    end else if (r_speed < w_target_ext) begin
                        if (r_duty < PWM_PERIOD && r_fan_on) begin
                            r_duty  <= r_duty + 1'b1;
                            r_accum <= '0;
                        end
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_out_valid || o_result.ready) begin
                        r_out_valid   <= 1'b1;
                        r_out_drive   <= r_drive;
                        r_out_duty    <= r_duty;
                        r_out_speed   <= r_speed;
                        r_out_fan_on  <= r_fan_on;
                        r_out_temp    <= r_temp;
                        r_out_request <= r_request;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (w_accept && t_op'(i_item.operation) == OP_TICK) begin
                // low raw bit marks whether the remainder division was launched
                r_raw[0] <= 1'b0;
            end
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.fan_drive      = r_out_drive;
    assign o_result.duty_level     = r_out_duty;
    assign o_result.fan_speed      = r_out_speed;
    assign o_result.motor_on       = r_out_fan_on;
    assign o_result.current_temp   = r_out_temp;
    assign o_result.sample_request = r_out_request;

endmodule

[test/fan_regulator_checker.sv]
`timescale 1ns / 100ps
module fan_regulator_checker import fpsr_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fpsr_item_if          i_item,
    fpsr_cfg_if           i_cfg,
    fpsr_result_if        i_result,
    output int            o_mismatches,
    output int            o_awaited
);

    localparam int RPM_SCALE    = 60;
    localparam int TARGET_SCALE = 40;

    typedef struct packed {
        logic               fan_drive;
        logic [DUTY_W-1:0]  duty_level;
        logic [SPEED_W-1:0] fan_speed;
        logic               motor_on;
        logic [TEMP_W-1:0]  current_temp;
        logic               sample_request;
    } t_fan_status;

    t_fan_status awaited_status[$];
    int          mismatches;

    logic [TEMP_W-1:0]  threshold;
    logic [TICK_W-1:0]  tick_cnt;
    logic [ACC_W-1:0]   pwm_acc;
    logic [DUTY_W-1:0]  duty;
    logic [PULSE_W-1:0] pulse_cnt;
    logic [SPEED_W-1:0] speed;
    logic [TEMP_W-1:0]  temp;
    logic               fan_on;
    logic               drive;

    function automatic t_fan_status next_fan_status(logic [OP_W-1:0] op,
                                                    logic [RAW_W-1:0] raw);
        t_fan_status        st;
        logic [RAW_W:0]     rounded;
        logic [15:0]        scaled_pulses;
        logic [15:0]        excess;
        logic [15:0]        scaled_excess;
        logic [15:0]        quot;
        int                 target;
        logic               sample_req;
        sample_req = 1'b0;
        case (op)
            OP_TICK: begin
                if (fan_on) begin
                    if (pwm_acc < PWM_PERIOD) begin
                        drive = 1'b0;
                    end else begin
                        drive = 1'b1;
                        pwm_acc = pwm_acc % PWM_PERIOD;
                    end
                    pwm_acc = pwm_acc + duty;
                end else begin
                    duty = DUTY_OFF_VALUE;
                    pwm_acc = '0;
                    drive = 1'b0;
                end
                if (tick_cnt == TICKS_PER_UPDATE) begin
                    tick_cnt = '0;
                    sample_req = 1'b1;
                    // speed from tach pulses, 16-bit wrap before the divide
                    scaled_pulses = pulse_cnt * RPM_SCALE;
                    speed = scaled_pulses / SPEED_DIVISOR;
                    pulse_cnt = '0;
                    excess = temp - threshold;
                    scaled_excess = excess * TARGET_SCALE;
                    quot = (temp != 0) ? scaled_excess / temp : '0;
                    target = 1 + quot % TARGET_MODULUS;
                    if (speed > target) begin
                        if (duty != 0 && fan_on) begin
                            duty = duty - 1'b1;
                            pwm_acc = '0;
                        end
                    end else if (speed < target) begin
                        if (duty < PWM_PERIOD && fan_on) begin
                            duty = duty + 1'b1;
                            pwm_acc = '0;
                        end
                    end
                end else begin
                    tick_cnt = tick_cnt + 1'b1;
                end
            end
            OP_PULSE: begin
                pulse_cnt = pulse_cnt + 1'b1;
            end
            OP_SAMPLE: begin
                rounded = raw + TEMP_ROUND;
                temp = rounded[TEMP_W+3:4];
                fan_on = temp > threshold;
            end
            default: begin
            end
        endcase
        st.fan_drive      = drive;
        st.duty_level     = duty;
        st.fan_speed      = speed;
        st.motor_on       = fan_on;
        st.current_temp   = temp;
        st.sample_request = sample_req;
        return st;
    endfunction

    function automatic int field_mismatch(string name, int expected, int actual);
        if (expected != actual) begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_fan_status exp_st;
        if (!i_rst_n) begin
            awaited_status.delete();
            mismatches = 0;
            threshold  = THRESHOLD_RESET;
            tick_cnt   = '0;
            pwm_acc    = '0;
            duty       = DUTY_OFF_VALUE;
            pulse_cnt  = '0;
            speed      = '0;
            temp       = '0;
            fan_on     = 1'b0;
            drive      = 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                threshold = i_cfg.threshold_temp;
            end
            if (i_item.valid && i_item.ready) begin
                awaited_status.push_back(next_fan_status(i_item.operation, i_item.sensor_raw));
            end
            if (i_result.valid && i_result.ready) begin
                if (awaited_status.size() == 0) begin
                    $error("result transaction with nothing awaited");
                    mismatches++;
                end else begin
                    exp_st = awaited_status.pop_front();
                    mismatches += field_mismatch("fan_drive", exp_st.fan_drive,
                                                 i_result.fan_drive);
                    mismatches += field_mismatch("duty_level", exp_st.duty_level,
                                                 i_result.duty_level);
                    mismatches += field_mismatch("fan_speed", exp_st.fan_speed,
                                                 i_result.fan_speed);
                    mismatches += field_mismatch("motor_on", exp_st.motor_on,
                                                 i_result.motor_on);
                    mismatches += field_mismatch("current_temp", exp_st.current_temp,
                                                 i_result.current_temp);
                    mismatches += field_mismatch("sample_request", exp_st.sample_request,
                                                 i_result.sample_request);
                end
            end
        end
        o_mismatches <= mismatches;
        o_awaited    <= awaited_status.size();
    end

endmodule

[test/fan_pwm_speed_regulator_tb.sv]
`timescale 1ns / 100ps
module fan_pwm_speed_regulator_tb;
    import fpsr_pkg::*;

    localparam int NUM_PHASES     = 6;
    localparam int PHASE_TICKS    = 166;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 100;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RESET_CYCLES   = 12;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   mismatches;
    int   awaited;
    int   hold_epoch = 0;
    logic steady_phase = 1'b0;
    int   quiet_cycles = 0;

    fpsr_item_if   item_ch ();
    fpsr_cfg_if    cfg_ch ();
    fpsr_result_if result_ch ();

    fan_pwm_speed_regulator u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .i_cfg    (cfg_ch),
        .o_result (result_ch)
    );

    fan_regulator_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_ch),
        .i_cfg        (cfg_ch),
        .i_result     (result_ch),
        .o_mismatches (mismatches),
        .o_awaited    (awaited)
    );

    always #1 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_phase || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    // raw reading that lands above a threshold below 255, so the fan runs; else random
    function automatic logic [RAW_W-1:0] warm_sample(int thr);
        if (thr >= 255) begin
            return RAW_W'($urandom);
        end
        return RAW_W'($urandom_range(thr + 1, 255) * 16 + $urandom_range(0, 7));
    endfunction

    task automatic send_item(logic [OP_W-1:0] op, logic [RAW_W-1:0] raw);
        int gap;
        item_ch.valid      <= 1'b1;
        item_ch.operation  <= op;
        item_ch.sensor_raw <= raw;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_threshold(logic [TEMP_W-1:0] value);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.threshold_temp <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain_results();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (awaited != 0) @(posedge i_clk);
    endtask

    // result side: random stalls, one long hold per epoch bump
    initial begin
        int stall_left;
        int seen_epoch;
        stall_left = 0;
        seen_epoch = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_epoch != seen_epoch) begin
                seen_epoch = hold_epoch;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && !steady_phase && $urandom_range(0, 99) < 25) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
            (result_ch.valid && result_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int thr;
        int pick;
        int pulses_left;
        int ticks_left;
        i_rst_n               <= 1'b0;
        item_ch.valid         <= 1'b0;
        item_ch.operation     <= OP_TICK;
        item_ch.sensor_raw    <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.threshold_temp <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, threshold at its reset value
        send_item(OP_UNUSED, 16'hFFFF);
        send_item(OP_TICK, 16'hFFFF);
        send_item(OP_SAMPLE, 16'h0000);
        send_item(OP_SAMPLE, 16'h0007);
        send_item(OP_SAMPLE, 16'h0008);
        send_item(OP_SAMPLE, 16'hFFF7);
        send_item(OP_SAMPLE, 16'hFFF8);   // rounding carries out of the top
        send_item(OP_SAMPLE, 16'd1280);   // equal to threshold
        send_item(OP_SAMPLE, 16'd1296);   // one above threshold
        repeat (6) send_item(OP_TICK, RAW_W'($urandom));
        send_item(OP_PULSE, 16'hFFFF);
        send_item(OP_PULSE, 16'h0000);
        send_item(OP_SAMPLE, 16'h0FF0);
        send_item(OP_TICK, 16'h0000);
        send_item(OP_TICK, 16'hFFFF);
        send_item(OP_SAMPLE, 16'd100);
        send_item(OP_TICK, 16'h0000);
        send_item(OP_UNUSED, 16'h0000);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_results();
            steady_phase = (phase % 4 == 3);
            case (phase)
                0: thr = 0;
                1: thr = 255;
                2: thr = THRESHOLD_RESET;
                3: thr = 1;
                4: thr = 254;
                default: thr = $urandom_range(0, 255);
            endcase
            write_threshold(TEMP_W'(thr));
            if (phase == 2) begin
                send_item(OP_SAMPLE, RAW_W'($urandom_range(0, 7)));
            end else begin
                send_item(OP_SAMPLE, warm_sample(thr));
            end
            case (phase)
                0: pulses_left = 0;
                5: pulses_left = 24;
                default: pulses_left = $urandom_range(0, 8);
            endcase
            if (phase == 4) begin
                hold_epoch++;
            end
            ticks_left = PHASE_TICKS;
            while (ticks_left + pulses_left > 0) begin
                pick = $urandom_range(0, 999);
                if (pick < 2) begin
                    send_item(OP_SAMPLE, RAW_W'($urandom));
                end else if (pick < 4) begin
                    send_item(OP_SAMPLE, warm_sample(thr));
                end else if (pick < 7) begin
                    send_item(OP_UNUSED, RAW_W'($urandom));
                end else if ($urandom_range(1, ticks_left + pulses_left) <= pulses_left) begin
                    send_item(OP_PULSE, RAW_W'($urandom));
                    pulses_left--;
                end else begin
                    send_item(OP_TICK, RAW_W'($urandom));
                    ticks_left--;
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && awaited == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[fan_pwm_speed_regulator.f]
sv/fpsr_pkg.sv
sv/fpsr_if.sv
sv/fpsr_div.sv
sv/fan_pwm_speed_regulator.sv
test/fan_regulator_checker.sv
test/fan_pwm_speed_regulator_tb.sv
